// ===== hw/rtl/tisx_pkg.sv =====
// Package for the timed input switcher: item structs, register indexes and constants.
// No dependencies.
`default_nettype none
package tisx_pkg;
    localparam int MASK_BITS = 8;
    localparam logic [31:0] MIN_STEP = 32'd655;
    localparam logic [15:0] MAX_FADE = 16'd65470;
    localparam logic [15:0] HALF_Q16 = 16'd32768;

    localparam logic [2:0] REG_MANUAL_MODE = 3'd0;
    localparam logic [2:0] REG_MANUAL_SLOT = 3'd1;
    localparam logic [2:0] REG_CLOCK_UNIT  = 3'd2;
    localparam logic [2:0] REG_INTERVAL    = 3'd3;
    localparam logic [2:0] REG_CROSSFADE   = 3'd4;

    typedef struct packed {
        logic [7:0]  connected_mask;
        logic [47:0] beat_clock;
        logic [47:0] second_clock;
    } in_item_t;

    typedef struct packed {
        logic        no_input;
        logic [2:0]  slot_a;
        logic [2:0]  slot_b;
        logic [15:0] mix_q16;
        logic [2:0]  active_slot;
    } out_item_t;

    // Classified job passed from the front end to the back end.
    typedef struct packed {
        logic        no_input;
        logic        single;
        logic [2:0]  single_slot;
        logic [7:0]  mask;
        logic [3:0]  count;
        logic [47:0] clk_val;
        logic [31:0] step;
        logic [15:0] fade;
    } job_t;
endpackage
`default_nettype wire

// ===== hw/rtl/tisx_front.sv =====
// Front end: accepts items, picks the clock, counts connected slots, resolves manual mode, clamps interval and fade.
// Depends on tisx_pkg.
`default_nettype none
module tisx_front #(
    parameter int SLOTS = 8
) (
    input  wire tisx_pkg::in_item_t item,
    input  wire logic              manual_mode,
    input  wire logic [7:0]        manual_slot,
    input  wire logic              clock_unit,
    input  wire logic [31:0]       interval_q16,
    input  wire logic [15:0]       crossfade_q16,
    output tisx_pkg::job_t         job
);
    logic [7:0] mask;
    logic [3:0] count;
    logic [2:0] first;
    logic [7:0] pick;
    logic       pick_ok;

    always_comb
    begin
        mask  = 8'd0;
        count = 4'd0;
        first = 3'd0;
        for (int i = tisx_pkg::MASK_BITS - 1; i >= 0; i--)
        begin
            if (i < SLOTS && item.connected_mask[i])
            begin
                mask[i] = 1'b1;
                first = 3'(i);
            end
        end
        for (int i = 0; i < tisx_pkg::MASK_BITS; i++)
            count = count + {3'd0, mask[i]};
        pick = (manual_slot > 8'(SLOTS - 1)) ? 8'(SLOTS - 1) : manual_slot;
        pick_ok = (pick < 8'(tisx_pkg::MASK_BITS)) && mask[pick[2:0]];
        job.no_input = (count == 4'd0);
        job.single = manual_mode || (count == 4'd1);
        job.single_slot = (manual_mode && pick_ok) ? pick[2:0] : first;
        job.mask = mask;
        job.count = count;
        job.clk_val = clock_unit ? item.second_clock : item.beat_clock;
        job.step = (interval_q16 < tisx_pkg::MIN_STEP) ? tisx_pkg::MIN_STEP : interval_q16;
        job.fade = (crossfade_q16 > tisx_pkg::MAX_FADE) ? tisx_pkg::MAX_FADE : crossfade_q16;
    end
endmodule
`default_nettype wire

// ===== hw/rtl/tisx_queue.sv =====
// Two-entry queue between front and back end.
// Depends on tisx_pkg.
`default_nettype none
module tisx_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire tisx_pkg::job_t wr_data,
    output logic                full,
    input  wire logic           rd_en,
    output tisx_pkg::job_t      rd_data,
    output logic                not_empty
);
    tisx_pkg::job_t mem [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full = cnt_reg == 2'd2;
    assign not_empty = cnt_reg != 2'd0;
    assign rd_data = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= ~wp_reg;
            if (rd_en)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) full |-> !wr_en)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !not_empty |-> !rd_en)
        else $error("queue read while empty");
    a_count: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue count out of range");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/tisx_back.sv =====
// Back end: restoring divisions for index, phase and mix, then slot lookup.
// Depends on tisx_pkg.
`default_nettype none
module tisx_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              job_valid,
    input  wire tisx_pkg::job_t    job,
    output logic                   job_take,
    output logic                   valid,
    input  wire logic              stall,
    output tisx_pkg::out_item_t    item
);
    typedef enum logic [2:0] {S_IDLE, S_IDX, S_PH, S_MIX, S_MOD, S_DONE} state_t;
    state_t state_reg;
    logic        valid_reg;
    logic [5:0]  cnt_reg;
    logic [47:0] quo_reg;
    logic [32:0] rem_reg;
    logic [31:0] step_reg;
    logic [15:0] fade_reg, edge_reg, phase_reg;
    logic [7:0]  mask_reg;
    logic [3:0]  count_reg;
    tisx_pkg::out_item_t out_reg;
    tisx_pkg::out_item_t out_next;

    logic [32:0] trial;
    logic [15:0] mix_w;
    logic [2:0]  sa, sb;
    logic [2:0]  ia;
    logic        emit_now;
    logic        emit_done;

    // Index modulo count, reduced serially beside the phase and mix divisions.
    logic [3:0]  mrem_reg;
    logic [5:0]  mcnt_reg;
    logic        mbusy_reg;
    logic [47:0] idx_reg;
    logic [4:0]  mtrial;

    assign item = out_reg;
    assign valid = valid_reg;
    assign job_take = (state_reg == S_IDLE) && job_valid && (!valid_reg || !stall);
    assign trial = {rem_reg[31:0], quo_reg[47]};
    assign mix_w = quo_reg[15:0];
    assign emit_now = job_take && (job.no_input || job.single);
    assign emit_done = (state_reg == S_DONE) && !mbusy_reg && (!valid_reg || !stall);

    // Pick the ia-th and next connected slot in ascending order.
    always_comb
    begin
        logic [3:0] k;
        logic [3:0] kb;
        k = 4'd0;
        sa = 3'd0;
        sb = 3'd0;
        kb = ({1'b0, ia} + 4'd1 == count_reg) ? 4'd0 : {1'b0, ia} + 4'd1;
        for (int i = 0; i < tisx_pkg::MASK_BITS; i++)
        begin
            if (mask_reg[i])
            begin
                if (k == {1'b0, ia})
                    sa = 3'(i);
                if (k == kb)
                    sb = 3'(i);
                k = k + 4'd1;
            end
        end
    end

    always_comb
    begin
        out_next = out_reg;
        if (emit_now)
        begin
            out_next = '0;
            out_next.no_input = job.no_input;
            if (!job.no_input)
            begin
                out_next.slot_a = job.single_slot;
                out_next.slot_b = job.single_slot;
                out_next.active_slot = job.single_slot;
            end
        end
        else if (emit_done)
        begin
            out_next.no_input = 1'b0;
            out_next.slot_a = sa;
            out_next.slot_b = sb;
            out_next.mix_q16 = mix_w;
            out_next.active_slot = (mix_w >= tisx_pkg::HALF_Q16) ? sb : sa;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
            cnt_reg <= 6'd0;
            quo_reg <= 48'd0;
            rem_reg <= 33'd0;
            step_reg <= 32'd0;
            fade_reg <= 16'd0;
            edge_reg <= 16'd0;
            phase_reg <= 16'd0;
            mask_reg <= 8'd0;
            count_reg <= 4'd0;
            out_reg <= '0;
        end
        else
        begin
            out_reg <= out_next;
            if (emit_now || emit_done)
                valid_reg <= 1'b1;
            else if (!stall)
                valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (job_take)
                    begin
                        step_reg <= job.step;
                        fade_reg <= job.fade;
                        edge_reg <= 16'(17'h10000 - {1'b0, job.fade});
                        mask_reg <= job.mask;
                        count_reg <= job.count;
                        quo_reg <= job.clk_val;
                        rem_reg <= 33'd0;
                        cnt_reg <= 6'd0;
                        if (!job.no_input && !job.single)
                            state_reg <= S_IDX;
                    end
                end
                S_IDX:
                begin
                    // One quotient bit per cycle of clock / step.
                    if (trial >= {1'b0, step_reg})
                    begin
                        rem_reg <= trial - {1'b0, step_reg};
                        quo_reg <= {quo_reg[46:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= trial;
                        quo_reg <= {quo_reg[46:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd47)
                        state_reg <= S_MOD;
                end
                S_MOD:
                begin
                    // The modulo unit captures the index in this cycle.
                    state_reg <= S_PH;
                    cnt_reg <= 6'd0;
                end
                S_PH:
                begin
                    if ({rem_reg[31:0], 1'b0} >= {1'b0, step_reg})
                    begin
                        rem_reg <= {rem_reg[31:0], 1'b0} - {1'b0, step_reg};
                        phase_reg <= {phase_reg[14:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[31:0], 1'b0};
                        phase_reg <= {phase_reg[14:0], 1'b0};
                    end
                    if (cnt_reg == 6'd15)
                    begin
                        state_reg <= S_MIX;
                        cnt_reg <= 6'd0;
                    end
                    else
                        cnt_reg <= cnt_reg + 6'd1;
                end
                S_MIX:
                begin
                    if (cnt_reg == 6'd0)
                    begin
                        rem_reg <= {17'd0, phase_reg - edge_reg};
                        quo_reg[15:0] <= 16'd0;
                        if (fade_reg == 16'd0 || phase_reg <= edge_reg)
                            state_reg <= S_DONE;
                    end
                    else if ({rem_reg[31:0], 1'b0} >= {17'd0, fade_reg})
                    begin
                        rem_reg <= {rem_reg[31:0], 1'b0} - {17'd0, fade_reg};
                        quo_reg[15:0] <= {quo_reg[14:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[31:0], 1'b0};
                        quo_reg[15:0] <= {quo_reg[14:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd16)
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    // Waits for the modulo unit and for room in the result register.
                    if (emit_done)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign mtrial = {mrem_reg, idx_reg[47]};
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mbusy_reg <= 1'b0;
            mcnt_reg <= 6'd0;
            idx_reg <= 48'd0;
            mrem_reg <= 4'd0;
        end
        else if (state_reg == S_MOD)
        begin
            idx_reg <= quo_reg;
            mrem_reg <= 4'd0;
            mcnt_reg <= 6'd0;
            mbusy_reg <= 1'b1;
        end
        else if (mbusy_reg)
        begin
            mrem_reg <= (mtrial >= {1'b0, count_reg}) ? 4'(mtrial - {1'b0, count_reg})
                                                        : mtrial[3:0];
            idx_reg <= {idx_reg[46:0], 1'b0};
            mcnt_reg <= mcnt_reg + 6'd1;
            if (mcnt_reg == 6'd47)
                mbusy_reg <= 1'b0;
        end
    end
    assign ia = mrem_reg[2:0];

`ifndef ASSERT_OFF
    a_idle_mod: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !mbusy_reg)
        else $error("modulo unit busy while idle");
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        job_take |-> state_reg == S_IDLE)
        else $error("job taken while busy");
    a_mix_single: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && out_reg.no_input |-> out_reg.mix_q16 == 16'd0)
        else $error("mix set with no input");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/timed_input_switcher_crossfade_top.sv =====
// Top level of the timed input switcher with crossfade.
// Depends on tisx_pkg, tisx_front, tisx_queue and tisx_back.
`default_nettype none
// One result per item. Items with no input, manual mode or a single connected slot
// go through the queue into the result register when the back end takes them, one
// per cycle while the result is not stalled. An automatic item holds the back end
// while it is taken, run through the bit-serial 48-bit clock/interval divider, its
// index handed over and reduced bit-serially modulo the connected count (the 16-step
// phase and up to 17-step mix divisions run beside it), and its result loaded. A
// stalled result holds the back end for as long as the stall lasts. A two-entry queue
// lets the front end accept items while the back end works; the input stalls when full.
module timed_input_switcher_crossfade_top #(
    parameter int SLOTS = 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire tisx_pkg::in_item_t  in_item,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output tisx_pkg::out_item_t      out_item,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [31:0]         cfg_data
);
    logic        manual_mode_reg, clock_unit_reg;
    logic [7:0]  manual_slot_reg;
    logic [31:0] interval_reg;
    logic [15:0] crossfade_reg;
    tisx_pkg::job_t fjob, qjob;
    logic q_full, q_ne, take;

    assign cfg_ready = 1'b1;
    assign in_stall = q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            manual_mode_reg <= 1'b0;
            manual_slot_reg <= 8'd0;
            clock_unit_reg <= 1'b0;
            interval_reg <= 32'd65536;
            crossfade_reg <= 16'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tisx_pkg::REG_MANUAL_MODE: manual_mode_reg <= cfg_data[0];
                tisx_pkg::REG_MANUAL_SLOT: manual_slot_reg <= cfg_data[7:0];
                tisx_pkg::REG_CLOCK_UNIT:  clock_unit_reg <= cfg_data[0];
                tisx_pkg::REG_INTERVAL:    interval_reg <= cfg_data;
                tisx_pkg::REG_CROSSFADE:   crossfade_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    tisx_front #(.SLOTS(SLOTS)) u_front (
        .item(in_item),
        .manual_mode(manual_mode_reg), .manual_slot(manual_slot_reg),
        .clock_unit(clock_unit_reg), .interval_q16(interval_reg),
        .crossfade_q16(crossfade_reg), .job(fjob)
    );

    tisx_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_en(in_valid && !q_full), .wr_data(fjob),
        .full(q_full), .rd_en(take), .rd_data(qjob), .not_empty(q_ne)
    );

    tisx_back u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(q_ne), .job(qjob), .job_take(take),
        .valid(out_valid), .stall(out_stall), .item(out_item)
    );
endmodule
`default_nettype wire
